// ----- design/pngunf_pkg.sv -----
// Shared types, constants and predictor helpers for the PNG row unfilter.
package pngunf_pkg;

    // Default row store depth (bytes per row at most)
    localparam int DEF_MAX_WIDTH = 4096;

    // Width of the row width register
    localparam int ROW_WIDTH_W = 13;

    // Pixel byte width
    localparam int BYTE_W = 8;

    // Row filter codes
    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } t_filter;

    // Paeth predictor: pick left, then up, then upper-left on ties
    function automatic logic [BYTE_W-1:0] paeth(
        input logic [BYTE_W-1:0] a,
        input logic [BYTE_W-1:0] b,
        input logic [BYTE_W-1:0] c
    );
        logic signed [10:0] sa;
        logic signed [10:0] sb;
        logic signed [10:0] sc;
        logic signed [10:0] da;
        logic signed [10:0] db;
        logic signed [10:0] dc;
        logic [9:0] pa;
        logic [9:0] pb;
        logic [9:0] pc;
        logic [BYTE_W-1:0] res;
        sa = signed'({3'b000, a});
        sb = signed'({3'b000, b});
        sc = signed'({3'b000, c});
        da = sb - sc;
        db = sa - sc;
        dc = sa + sb - sc - sc;
        pa = da[10] ? 10'(-da) : da[9:0];
        pb = db[10] ? 10'(-db) : db[9:0];
        pc = dc[10] ? 10'(-dc) : dc[9:0];
        if (pa <= pb && pa <= pc) begin
            res = a;
        end else if (pb <= pc) begin
            res = b;
        end else begin
            res = c;
        end
        return res;
    endfunction

    // Control fields of the word in the reconstruct stage
    typedef struct packed {
        logic          is_filter;
        logic          bad;
        t_filter       filter;
        logic          row_end;
        logic          zero_up;
    } t_s1_ctl;

endpackage

// ----- design/png_row_unfilter.sv -----
// Top level of the PNG row unfilter for 8-bit grayscale streams.
//
// Input channel: one stream byte per word (i_data_byte, i_new_stream), taken
// when i_valid is high and o_stall is low. Each row is a filter byte followed
// by row_width data bytes; i_new_stream marks the filter byte of a new image.
// Output channel: one reconstructed byte per data byte (o_pixel, o_row_end),
// taken when o_valid is high and i_stall is low. A filter byte above four
// gives one word with o_bad_filter set, and its row decodes as filter none.
// Config channel: i_cfg_valid/o_cfg_ready write row_width (always ready).
// A data byte reaches the output through two register stages, reconstruct
// and output.
// Throughput: one byte per cycle when not stalled; the previous row lives in
// a RAM read when a byte is taken and written back when its pixel is built.
// Reset clears the control state; the row store itself is not cleared, and
// the first row of a stream reads its upper row as zero.
// When the receiver stalls, the output word holds, the reconstruct stage
// fills, and o_stall rises in the same cycle so no word is lost.
module png_row_unfilter
    import pngunf_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [ROW_WIDTH_W-1:0] i_cfg_row_width,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [BYTE_W-1:0]      i_data_byte,
    input  logic                   i_new_stream,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [BYTE_W-1:0]      o_pixel,
    output logic                   o_row_end,
    output logic                   o_bad_filter
);

    localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int MWW = $clog2(MAX_WIDTH + 1);
    localparam int CW  = (MWW > ROW_WIDTH_W) ? MWW : ROW_WIDTH_W;

    // Config and front-end state
    logic [ROW_WIDTH_W-1:0] r_row_width;
    logic [AW-1:0]          r_column;
    logic                   r_expect_filter;
    logic                   r_first_row;
    t_filter                r_filter;

    // Reconstruct stage
    logic                   r_s1_valid;
    t_s1_ctl                r_s1;
    logic [BYTE_W-1:0]      r_s1_raw;
    logic [AW-1:0]          r_s1_col;
    logic [BYTE_W-1:0]      r_left;
    logic [BYTE_W-1:0]      r_upleft;

    // Output word
    logic                   r_o_valid;
    logic [BYTE_W-1:0]      r_o_pixel;
    logic                   r_o_row_end;
    logic                   r_o_bad;

    logic                   out_ready;
    logic                   s1_free;
    logic                   in_acc;
    logic                   is_filt;
    logic                   bad_code;
    logic [CW-1:0]          w_raw;
    logic [CW-1:0]          w_eff;
    logic [CW-1:0]          col_next;
    logic                   row_end;
    t_s1_ctl                n_s1;
    logic [BYTE_W-1:0]      ram_q;
    logic [BYTE_W-1:0]      up;
    logic [BYTE_W-1:0]      pix;
    logic                   ram_we;
    logic                   s1_has_out;

    // Handshakes
    assign out_ready   = !r_o_valid || !i_stall;
    assign s1_free     = !r_s1_valid || out_ready;
    assign o_stall     = !s1_free;
    assign in_acc      = i_valid && s1_free;
    assign o_cfg_ready = 1'b1;

    // Effective row width: zero acts as one, clamp to the store depth
    assign w_raw = CW'(r_row_width);
    always_comb begin
        if (w_raw == '0) begin
            w_eff = CW'(1);
        end else if (w_raw > CW'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = w_raw;
        end
    end

    // Classify the incoming byte
    assign is_filt  = i_new_stream || r_expect_filter;
    assign bad_code = i_data_byte > BYTE_W'(FILT_PAETH);
    assign col_next = CW'(r_column) + CW'(1);
    assign row_end  = col_next >= w_eff;

    always_comb begin
        n_s1.is_filter = is_filt;
        n_s1.bad       = is_filt && bad_code;
        n_s1.filter    = r_filter;
        n_s1.row_end   = row_end;
        n_s1.zero_up   = r_first_row;
    end

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= ROW_WIDTH_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_row_width <= i_cfg_row_width;
        end
    end

    // Advance row position and filter on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column        <= '0;
            r_expect_filter <= 1'b1;
            r_first_row     <= 1'b1;
            r_filter        <= FILT_NONE;
        end else if (in_acc) begin
            if (is_filt) begin
                r_column        <= '0;
                r_expect_filter <= 1'b0;
                r_filter        <= bad_code ? FILT_NONE : t_filter'(i_data_byte[2:0]);
                if (i_new_stream) begin
                    r_first_row <= 1'b1;
                end
            end else if (row_end) begin
                r_column        <= '0;
                r_expect_filter <= 1'b1;
                r_first_row     <= 1'b0;
            end else begin
                r_column <= col_next[AW-1:0];
            end
        end
    end

    // Previous row store: read on accept, write back on reconstruct
    assign ram_we = r_s1_valid && out_ready && !r_s1.is_filter;

    pngunf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_col),
        .i_wdata (pix),
        .i_re    (in_acc && !is_filt),
        .i_raddr (r_column),
        .o_rdata (ram_q)
    );

    // Stage register into reconstruct
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1     <= n_s1;
            r_s1_raw <= i_data_byte;
            r_s1_col <= r_column;
        end
    end

    // Rebuild the pixel
    assign up = r_s1.zero_up ? '0 : ram_q;

    pngunf_recon u_recon (
        .i_filter (r_s1.filter),
        .i_raw    (r_s1_raw),
        .i_left   (r_left),
        .i_up     (up),
        .i_upleft (r_upleft),
        .o_pixel  (pix)
    );

    // Track left and upper-left neighbors
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_upleft <= '0;
        end else if (r_s1_valid && out_ready) begin
            if (r_s1.is_filter) begin
                r_left   <= '0;
                r_upleft <= '0;
            end else begin
                r_left   <= pix;
                r_upleft <= up;
            end
        end
    end

    // Output register
    assign s1_has_out = !r_s1.is_filter || r_s1.bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_ready) begin
            r_o_valid <= r_s1_valid && s1_has_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_s1_valid) begin
            r_o_pixel   <= r_s1.is_filter ? '0 : pix;
            r_o_row_end <= !r_s1.is_filter && r_s1.row_end;
            r_o_bad     <= r_s1.bad;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_pixel      = r_o_pixel;
    assign o_row_end    = r_o_row_end;
    assign o_bad_filter = r_o_bad;

endmodule

// ----- design/pngunf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pngunf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, holds its data until the next enabled read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/pngunf_recon.sv -----
// Predictor and modulo-256 add that rebuild one pixel byte.
module pngunf_recon
    import pngunf_pkg::*;
(
    input  t_filter           i_filter,
    input  logic [BYTE_W-1:0] i_raw,
    input  logic [BYTE_W-1:0] i_left,
    input  logic [BYTE_W-1:0] i_up,
    input  logic [BYTE_W-1:0] i_upleft,
    output logic [BYTE_W-1:0] o_pixel
);

    logic [BYTE_W:0]   avg_sum;
    logic [BYTE_W-1:0] pred;

    assign avg_sum = {1'b0, i_left} + {1'b0, i_up};

    // Select the predictor of the row's filter
    always_comb begin
        case (i_filter)
            FILT_SUB:   pred = i_left;
            FILT_UP:    pred = i_up;
            FILT_AVG:   pred = avg_sum[BYTE_W:1];
            FILT_PAETH: pred = paeth(i_left, i_up, i_upleft);
            default:    pred = '0;
        endcase
    end

    // Add the predictor, wrapping at 256
    assign o_pixel = pred + i_raw;

endmodule
